### rtl/irpw_pkg.sv
package irpw_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SHORT_MARK   = 3'd0;
    localparam logic [2:0] REG_LONG_MARK    = 3'd1;
    localparam logic [2:0] REG_SPACE        = 3'd2;
    localparam logic [2:0] REG_CARRIER_HALF = 3'd3;
    localparam logic [2:0] REG_CARRIER_EN   = 3'd4;

    // Reset values: 100 us / 500 us at a 9.6 MHz tick, carrier compare 126 + 1
    localparam logic [15:0] RST_SHORT_MARK   = 16'd960;
    localparam logic [15:0] RST_LONG_MARK    = 16'd4800;
    localparam logic [15:0] RST_SPACE        = 16'd4800;
    localparam logic [8:0]  RST_CARRIER_HALF = 9'd127;
    localparam logic        RST_CARRIER_EN   = 1'b1;

    // Input request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    typedef struct packed {
        logic [15:0] short_mark_ticks;
        logic [15:0] long_mark_ticks;
        logic [15:0] space_ticks;
        logic [8:0]  carrier_half_period;
        logic        carrier_enable;
    } t_cfg;

    typedef struct packed {
        logic tx_level;
        logic busy;
        logic done;
    } t_result;

    // A length of zero counts as one
    function automatic logic [15:0] f_min1_len(input logic [15:0] v);
        f_min1_len = (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic [8:0] f_min1_half(input logic [8:0] v);
        f_min1_half = (v == 9'd0) ? 9'd1 : v;
    endfunction

endpackage

### rtl/ir_pulse_width_transmitter_core.sv
// Pulse-width IR transmitter core.
// Input channel (i_valid / o_stall): each item is either one tick of the
// timing base (i_req_type = 0) or a request to send i_code_byte
// (i_req_type = 1). A send request while busy is ignored. Every item gives
// exactly one result on the output channel (o_valid / i_stall): the pin
// level after the item, the busy flag and a done pulse on the tick that
// ends the last space.
// The result is registered: it appears in the output register in the cycle
// after its item is taken. One item per cycle is taken while o_stall is low;
// the next state is formed in one pass of logic from the state registers.
// Stall: while the output register holds a result and the receiver stalls,
// o_stall is raised and no item is taken, so no tick is lost.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) writes the five
// timing registers; write it only while no item is in flight. New lengths
// take effect when the next mark or space begins.
// Reset (synchronous, i_rst_n low) returns the engine to idle, the
// output register empty and the timing registers at their defaults.
module ir_pulse_width_transmitter_core
    import irpw_pkg::*;
#(
    parameter int BITS_PER_CODE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_code_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    accept;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    irpw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    irpw_symbol_engine #(
        .BITS_PER_CODE (BITS_PER_CODE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_code_byte (i_code_byte),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // Output register: refilled on every taken item, emptied when read
    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_tx_level = r_out.tx_level;
    assign o_busy_res = r_out.busy;
    assign o_done_res = r_out.done;

    // Every taken item shows up as a result in the next cycle
    a_item_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("taken item produced no result");

    // Done is never reported together with busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done |-> !r_out.busy && !r_out.tx_level)
        else $error("done reported while still sending");

endmodule

### rtl/irpw_cfg_regs.sv
module irpw_cfg_regs
    import irpw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHORT_MARK:   n_cfg.short_mark_ticks    = i_cfg_data;
                REG_LONG_MARK:    n_cfg.long_mark_ticks     = i_cfg_data;
                REG_SPACE:        n_cfg.space_ticks         = i_cfg_data;
                REG_CARRIER_HALF: n_cfg.carrier_half_period = i_cfg_data[8:0];
                REG_CARRIER_EN:   n_cfg.carrier_enable      = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_mark_ticks    <= RST_SHORT_MARK;
            r_cfg.long_mark_ticks     <= RST_LONG_MARK;
            r_cfg.space_ticks         <= RST_SPACE;
            r_cfg.carrier_half_period <= RST_CARRIER_HALF;
            r_cfg.carrier_enable      <= RST_CARRIER_EN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

### rtl/irpw_symbol_engine.sv
module irpw_symbol_engine
    import irpw_pkg::*;
#(
    parameter int BITS_PER_CODE = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_req_type,
    input  logic [7:0] i_code_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int IDX_W = (BITS_PER_CODE > 1) ? $clog2(BITS_PER_CODE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BITS_PER_CODE - 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MARK  = 2'd1,
        PH_SPACE = 2'd2
    } t_phase;

    t_phase                   r_phase,     n_phase;
    logic [BITS_PER_CODE-1:0] r_shift,     n_shift;
    logic [IDX_W-1:0]         r_bit_idx,   n_bit_idx;
    logic [15:0]              r_duration,  n_duration;
    logic [8:0]               r_car_cnt,   n_car_cnt;
    logic                     r_car_level, n_car_level;
    logic                     n_done;
    logic [8:0]               car_inc;

    assign car_inc = r_car_cnt + 9'd1;

    // Next state for one item: a send request or one tick
    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bit_idx   = r_bit_idx;
        n_duration  = r_duration;
        n_car_cnt   = r_car_cnt;
        n_car_level = r_car_level;
        n_done      = 1'b0;
        if (i_req_type == REQ_SEND) begin
            // ignored while busy
            if (r_phase == PH_IDLE) begin
                n_shift     = BITS_PER_CODE'(i_code_byte);
                n_bit_idx   = '0;
                n_phase     = PH_MARK;
                n_duration  = f_min1_len(i_code_byte[0] ? i_cfg.long_mark_ticks
                                                        : i_cfg.short_mark_ticks);
                n_car_cnt   = '0;
                n_car_level = 1'b0;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_MARK: begin
                    if (car_inc >= f_min1_half(i_cfg.carrier_half_period)) begin
                        n_car_cnt   = '0;
                        n_car_level = ~r_car_level;
                    end else begin
                        n_car_cnt = car_inc;
                    end
                    if (r_duration <= 16'd1) begin
                        n_phase     = PH_SPACE;
                        n_duration  = f_min1_len(i_cfg.space_ticks);
                        n_car_cnt   = '0;
                        n_car_level = 1'b0;
                    end else begin
                        n_duration = r_duration - 16'd1;
                    end
                end
                PH_SPACE: begin
                    if (r_duration <= 16'd1) begin
                        if (r_bit_idx == LAST_IDX) begin
                            n_phase    = PH_IDLE;
                            n_duration = '0;
                            n_bit_idx  = '0;
                            n_shift    = '0;
                            n_done     = 1'b1;
                        end else begin
                            n_bit_idx   = r_bit_idx + IDX_W'(1);
                            n_shift     = r_shift >> 1;
                            n_phase     = PH_MARK;
                            n_duration  = f_min1_len(r_shift[1 % BITS_PER_CODE]
                                                     ? i_cfg.long_mark_ticks
                                                     : i_cfg.short_mark_ticks);
                            n_car_cnt   = '0;
                            n_car_level = 1'b0;
                        end
                    end else begin
                        n_duration = r_duration - 16'd1;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Result reflects the state after this item; carrier enable is taken live
    always_comb begin
        o_result.tx_level = (n_phase == PH_MARK) &&
                            (i_cfg.carrier_enable ? n_car_level : 1'b1);
        o_result.busy     = (n_phase != PH_IDLE);
        o_result.done     = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_shift     <= '0;
            r_bit_idx   <= '0;
            r_duration  <= '0;
            r_car_cnt   <= '0;
            r_car_level <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bit_idx   <= n_bit_idx;
            r_duration  <= n_duration;
            r_car_cnt   <= n_car_cnt;
            r_car_level <= n_car_level;
        end
    end

    // A send request while idle always starts a mark
    a_send_starts_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_req_type == REQ_SEND) && (r_phase == PH_IDLE)
        |=> r_phase == PH_MARK)
        else $error("send request did not start a mark");

    // Idle leaves no ticks pending
    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_duration == 16'd0)
        else $error("duration counter not clear while idle");

    // Carrier only runs inside a mark
    a_carrier_in_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_MARK |-> !r_car_level && (r_car_cnt == 9'd0))
        else $error("carrier active outside a mark");

    // Done ends the code and leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.done |=> r_phase == PH_IDLE && r_bit_idx == '0)
        else $error("done without returning to idle");

endmodule

### test/ir_pulse_width_transmitter_core_test.sv
import irpw_pkg::*;

localparam int CODE_BITS = 8;

typedef enum logic [1:0] {TXPH_IDLE, TXPH_MARK, TXPH_SPACE} t_tx_phase;

// Symbol timing predictor plus the queue of pin levels still owed by the block
class t_pulse_board;
    logic [15:0] short_len;
    logic [15:0] long_len;
    logic [15:0] space_len;
    logic [8:0]  half_len;
    logic        carrier_on;
    logic [7:0]  code_bits;
    logic [2:0]  bit_pos;
    t_tx_phase   phase_now;
    logic [15:0] ticks_left;
    logic [8:0]  carrier_cnt;
    logic        carrier_lvl;
    t_result     due_results[$];
    int          err_count;

    function new();
        short_len   = 16'd960;
        long_len    = 16'd4800;
        space_len   = 16'd4800;
        half_len    = 9'd127;
        carrier_on  = 1'b1;
        code_bits   = 8'd0;
        bit_pos     = 3'd0;
        phase_now   = TXPH_IDLE;
        ticks_left  = 16'd0;
        carrier_cnt = 9'd0;
        carrier_lvl = 1'b0;
        err_count   = 0;
    endfunction

    function logic [15:0] len_or_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function void set_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_SHORT_MARK:   short_len = data;
            REG_LONG_MARK:    long_len = data;
            REG_SPACE:        space_len = data;
            REG_CARRIER_HALF: half_len = data[8:0];
            REG_CARRIER_EN:   carrier_on = data[0];
            default: ;
        endcase
    endfunction

    // mark length follows the current LSB; carrier restarts low
    function void start_mark();
        phase_now   = TXPH_MARK;
        ticks_left  = len_or_one(code_bits[0] ? long_len : short_len);
        carrier_cnt = 9'd0;
        carrier_lvl = 1'b0;
    endfunction

    function bit busy();
        return phase_now != TXPH_IDLE;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void predict_item(input logic req, input logic [7:0] code);
        t_result r;
        logic    fin;
        fin = 1'b0;
        if (req == REQ_SEND) begin
            // a send while busy is dropped and no tick passes
            if (phase_now == TXPH_IDLE) begin
                code_bits = code;
                bit_pos   = 3'd0;
                start_mark();
            end
        end else if (phase_now == TXPH_MARK) begin
            carrier_cnt = carrier_cnt + 9'd1;
            if (carrier_cnt >= ((half_len == 9'd0) ? 9'd1 : half_len)) begin
                carrier_cnt = 9'd0;
                carrier_lvl = ~carrier_lvl;
            end
            if (ticks_left <= 16'd1) begin
                phase_now   = TXPH_SPACE;
                ticks_left  = len_or_one(space_len);
                carrier_cnt = 9'd0;
                carrier_lvl = 1'b0;
            end else begin
                ticks_left = ticks_left - 16'd1;
            end
        end else if (phase_now == TXPH_SPACE) begin
            if (ticks_left <= 16'd1) begin
                if (int'(bit_pos) + 1 >= CODE_BITS) begin
                    phase_now  = TXPH_IDLE;
                    ticks_left = 16'd0;
                    bit_pos    = 3'd0;
                    code_bits  = 8'd0;
                    fin        = 1'b1;
                end else begin
                    bit_pos   = bit_pos + 3'd1;
                    code_bits = code_bits >> 1;
                    start_mark();
                end
            end else begin
                ticks_left = ticks_left - 16'd1;
            end
        end
        r.tx_level = (phase_now == TXPH_MARK) && (carrier_on ? carrier_lvl : 1'b1);
        r.busy     = (phase_now != TXPH_IDLE);
        r.done     = fin;
        due_results.push_back(r);
    endfunction

    function void check_bit(input string field, input logic want, input logic got,
                            input time stamp);
        if (got !== want) begin
            $display("%0t: %s expected %0b actual %0b", stamp, field, want, got);
            err_count++;
        end
    endfunction

    function void compare_result(input logic tx, input logic bsy, input logic dn,
                                 input time stamp);
        t_result want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected item tx %0b busy %0b done %0b expected none",
                     stamp, tx, bsy, dn);
            err_count++;
            return;
        end
        want = due_results.pop_front();
        check_bit("tx_level", want.tx_level, tx, stamp);
        check_bit("busy_res", want.busy, bsy, stamp);
        check_bit("done_res", want.done, dn, stamp);
    endfunction
endclass

module ir_pulse_width_transmitter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    // index with no register behind it
    localparam logic [2:0] REG_NONE = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_req_type  = 1'b0;
    logic [7:0]  i_code_byte = 8'd0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic        o_tx_level;
    logic        o_busy_res;
    logic        o_done_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [15:0] i_cfg_data  = 16'd0;

    t_pulse_board board = new();

    int tx_mode   = 0;
    int rx_mode   = 0;
    bit hold_off  = 1'b0;
    int sent_items = 0;

    ir_pulse_width_transmitter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_code_byte (i_code_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tx_level  (o_tx_level),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // mode 0: back to back, 1: a random wait before every item, 2: occasional waits
    function automatic int draw_gap(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 2 && $urandom_range(3) != 0)
            return 0;
        return $urandom_range(19);
    endfunction

    function automatic logic [15:0] pick_len(input int top);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 16'd0;
        if (r < 15)
            return 16'($urandom_range(40, top + 1));
        return 16'($urandom_range(top, 1));
    endfunction

    function automatic logic [15:0] pick_half();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 16'($urandom);
        if (r < 15)
            return 16'($urandom_range(511, 6));
        if (r < 25)
            return 16'd0;
        return 16'($urandom_range(5, 1));
    endfunction

    function automatic logic [15:0] pick_enable();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(1));
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic req, input logic [7:0] code);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_code_byte <= code;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        board.predict_item(req, code);
        sent_items++;
    endtask

    // valid is left high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        board.set_register(idx, data);
    endtask

    task automatic apply_settings(input logic [15:0] s, input logic [15:0] l,
                                  input logic [15:0] sp, input logic [15:0] h,
                                  input logic [15:0] e, input logic [4:0] sel);
        if (sel[REG_SHORT_MARK])   write_reg(REG_SHORT_MARK, s);
        if (sel[REG_LONG_MARK])    write_reg(REG_LONG_MARK, l);
        if (sel[REG_SPACE])        write_reg(REG_SPACE, sp);
        if (sel[REG_CARRIER_HALF]) write_reg(REG_CARRIER_HALF, h);
        if (sel[REG_CARRIER_EN])   write_reg(REG_CARRIER_EN, e);
        i_cfg_valid <= 1'b0;
    endtask

    // tick until the byte is out; noise is the percent of sends thrown in
    task automatic finish_byte(input int noise);
        while (board.busy()) begin
            if ($urandom_range(99) < noise)
                send_item(REQ_SEND, 8'($urandom));
            else
                send_item(REQ_TICK, 8'($urandom));
        end
    endtask

    task automatic run_byte(input logic [7:0] code, input int noise);
        send_item(REQ_SEND, code);
        finish_byte(noise);
    endtask

    // stop offering and wait for every owed result
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        int held;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off) begin
                i_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = draw_gap(rx_mode);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.compare_result(o_tx_level, o_busy_res, o_done_res, $time);
    end

    // watchdog
    initial begin
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int phase_no;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing; idle ticks, then a send with a second send dropped
        send_item(REQ_TICK, 8'hFF);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_SEND, 8'h80);
        send_item(REQ_SEND, 8'h3C);
        // most of the default short mark with the default carrier
        repeat (950) send_item(REQ_TICK, 8'($urandom));
        drain();

        // shortest lengths, zero half period toggles every tick, code extremes;
        // the rest of the first byte picks up the new space length
        tx_mode = 1;
        rx_mode = 1;
        apply_settings(16'd1, 16'd2, 16'd1, 16'd0, 16'd1, '1);
        finish_byte(0);
        run_byte(8'hFF, 0);
        run_byte(8'h00, 0);
        drain();

        // steady marks; zero lengths act as one tick
        tx_mode = 2;
        rx_mode = 2;
        apply_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, '1);
        run_byte(8'h5A, 0);
        run_byte(8'hA5, 30);
        drain();

        // after an unknown index write, a long first mark that outlasts the carrier half period
        tx_mode = 0;
        rx_mode = 0;
        write_reg(REG_NONE, 16'hFFFF);
        apply_settings(16'd1, 16'd300, 16'd1, 16'd256, 16'd1, '1);
        run_byte(8'h01, 0);
        drain();

        // random phases: new timing, then a few bytes with idle ticks and noise
        sent_items = 0;
        phase_no = 0;
        while (sent_items < RANDOM_ITEMS) begin
            drain();
            apply_settings(pick_len(6), pick_len(10), pick_len(6), pick_half(),
                           pick_enable(),
                           (phase_no == 0) ? 5'h1F : (5'($urandom) | 5'($urandom)));
            tx_mode = $urandom_range(2);
            rx_mode = $urandom_range(2);
            if (phase_no == 0) begin
                tx_mode = 0;
                hold_off = 1'b1;
            end
            repeat ($urandom_range(4, 1)) begin
                repeat ($urandom_range(3)) send_item(REQ_TICK, 8'($urandom));
                run_byte(8'($urandom), 5);
            end
            phase_no++;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (board.err_count == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
